// ----- rtl/tndh_pkg.sv -----
// Package for the trimmed numeric-or-hash block: constants, item structs,
// result kinds and the xor-djb2 step. No dependencies.
package tndh_pkg;

    localparam logic [63:0] SEED      = 64'd5381;
    localparam logic [30:0] MIX_MUL   = 31'd1566083941;
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_PRE   = 64'd922337203685477580;

    typedef enum logic [1:0] {
        RES_EMPTY,
        RES_NUMBER,
        RES_HASH
    } res_kind_t;

    // Classified input item, as stored in the queue.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       byte_valid;
        logic       last;
        logic       ws;
        logic       digit;
        logic       sign;
        logic       minus;
        logic [3:0] digit_val;
    } cls_item_t;

    // Operands for finishing one string.
    typedef struct packed {
        res_kind_t   kind;
        logic [63:0] h_even;
        logic [63:0] h_odd;
        logic        negative;
        logic        saturated;
        logic [63:0] accum;
    } fin_item_t;

    function automatic logic [63:0] djb_step(logic [63:0] h, logic [7:0] b);
        return ((h << 5) + h) ^ {{56{b[7]}}, b};
    endfunction

endpackage

// ----- rtl/tndh_if.sv -----
// Channel interfaces of the trimmed numeric-or-hash block: byte items in,
// result items out. No dependencies.
interface tndh_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       byte_valid;
    logic       last;

    modport source (output valid, byte_in, byte_valid, last, input ready);
    modport sink   (input valid, byte_in, byte_valid, last, output ready);
endinterface

interface tndh_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic               was_numeric;

    modport source (output valid, value, was_numeric, input ready);
    modport sink   (input valid, value, was_numeric, output ready);
endinterface

// ----- rtl/tndh_front.sv -----
// Front end: accepts byte items and classifies each byte.
// Depends on tndh_pkg and tndh_text_if.
module tndh_front (
    tndh_text_if.sink          text,
    input  logic               q_full,
    output logic               push,
    output tndh_pkg::cls_item_t item
);
    import tndh_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    logic [7:0] b;

    assign b          = text.byte_in;
    assign text.ready = !q_full;
    assign push       = text.valid && !q_full;

    always_comb
    begin
        item.byte_in    = b;
        item.byte_valid = text.byte_valid;
        item.last       = text.last;
        item.ws         = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        item.digit      = (b >= CH_ZERO) && (b <= CH_NINE);
        item.sign       = (b == CH_PLUS) || (b == CH_MINUS);
        item.minus      = (b == CH_MINUS);
        item.digit_val  = b[3:0];
    end

endmodule

// ----- rtl/tndh_queue.sv -----
// Two-entry queue of classified items between front and back end.
// Depends on tndh_pkg.
module tndh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tndh_pkg::cls_item_t wr_item,
    input  logic                pop,
    output tndh_pkg::cls_item_t rd_item,
    output logic                empty,
    output logic                full
);
    import tndh_pkg::*;

    cls_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- rtl/tndh_back.sv -----
// Back end: trims, parses and hashes one byte item per cycle while pop is high
// and hands the operands of a finished string to the mixer. Depends on tndh_pkg.
module tndh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop,
    input  tndh_pkg::cls_item_t item,
    output logic                fin_valid,
    output tndh_pkg::fin_item_t fin
);
    import tndh_pkg::*;

    logic [63:0] hec_reg, hoc_reg, hep_reg, hop_reg;
    logic [63:0] hec_next, hoc_next, hep_next, hop_next;
    logic        odd_reg, started_reg, space_reg, numeric_ok_reg;
    logic        odd_next, started_next, space_next, numeric_ok_next;
    logic        negative_reg, digit_seen_reg, saturated_reg;
    logic        negative_next, digit_seen_next, saturated_next;
    logic [63:0] accum_reg, accum_next;

    logic [63:0] u_hec, u_hoc, u_hep, u_hop, u_accum, times_ten;
    logic        u_odd, u_started, u_space, u_numeric_ok;
    logic        u_negative, u_digit_seen, u_saturated;

    assign times_ten = (accum_reg << 3) + (accum_reg << 1) + {60'd0, item.digit_val};

    always_comb
    begin
        u_hec        = hec_reg;
        u_hoc        = hoc_reg;
        u_hep        = hep_reg;
        u_hop        = hop_reg;
        u_odd        = odd_reg;
        u_started    = started_reg;
        u_space      = space_reg;
        u_numeric_ok = numeric_ok_reg;
        u_negative   = negative_reg;
        u_digit_seen = digit_seen_reg;
        u_saturated  = saturated_reg;
        u_accum      = accum_reg;

        if (item.byte_valid && !(item.ws && !started_reg))
        begin
            if (odd_reg)
            begin
                u_hop = djb_step(hop_reg, item.byte_in);
            end
            else
            begin
                u_hep = djb_step(hep_reg, item.byte_in);
            end
            u_odd = !odd_reg;

            if (item.ws)
            begin
                u_space = 1'b1;
            end
            else
            begin
                if (space_reg)
                begin
                    u_numeric_ok = 1'b0;
                end
                u_space = 1'b0;
                if (u_numeric_ok)
                begin
                    priority if (!started_reg && item.sign)
                    begin
                        u_negative = item.minus;
                    end
                    else if (item.digit)
                    begin
                        u_digit_seen = 1'b1;
                        if (!saturated_reg)
                        begin
                            if (accum_reg > MAG_PRE || times_ten > MAG_LIMIT)
                            begin
                                u_saturated = 1'b1;
                            end
                            else
                            begin
                                u_accum = times_ten;
                            end
                        end
                    end
                    else
                    begin
                        u_numeric_ok = 1'b0;
                    end
                end
                u_started = 1'b1;
                u_hec     = u_hep;
                u_hoc     = u_hop;
            end
        end
    end

    always_comb
    begin
        fin_valid     = pop && item.last;
        fin.h_even    = u_hec;
        fin.h_odd     = u_hoc;
        fin.negative  = u_negative;
        fin.saturated = u_saturated;
        fin.accum     = u_accum;
        priority if (!u_started)
        begin
            fin.kind = RES_EMPTY;
        end
        else if (u_numeric_ok && u_digit_seen)
        begin
            fin.kind = RES_NUMBER;
        end
        else
        begin
            fin.kind = RES_HASH;
        end
    end

    always_comb
    begin
        hec_next        = hec_reg;
        hoc_next        = hoc_reg;
        hep_next        = hep_reg;
        hop_next        = hop_reg;
        odd_next        = odd_reg;
        started_next    = started_reg;
        space_next      = space_reg;
        numeric_ok_next = numeric_ok_reg;
        negative_next   = negative_reg;
        digit_seen_next = digit_seen_reg;
        saturated_next  = saturated_reg;
        accum_next      = accum_reg;
        if (pop)
        begin
            if (item.last)
            begin
                hec_next        = SEED;
                hoc_next        = SEED;
                hep_next        = SEED;
                hop_next        = SEED;
                odd_next        = 1'b0;
                started_next    = 1'b0;
                space_next      = 1'b0;
                numeric_ok_next = 1'b1;
                negative_next   = 1'b0;
                digit_seen_next = 1'b0;
                saturated_next  = 1'b0;
                accum_next      = 64'd0;
            end
            else
            begin
                hec_next        = u_hec;
                hoc_next        = u_hoc;
                hep_next        = u_hep;
                hop_next        = u_hop;
                odd_next        = u_odd;
                started_next    = u_started;
                space_next      = u_space;
                numeric_ok_next = u_numeric_ok;
                negative_next   = u_negative;
                digit_seen_next = u_digit_seen;
                saturated_next  = u_saturated;
                accum_next      = u_accum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hec_reg        <= SEED;
            hoc_reg        <= SEED;
            hep_reg        <= SEED;
            hop_reg        <= SEED;
            odd_reg        <= 1'b0;
            started_reg    <= 1'b0;
            space_reg      <= 1'b0;
            numeric_ok_reg <= 1'b1;
            negative_reg   <= 1'b0;
            digit_seen_reg <= 1'b0;
            saturated_reg  <= 1'b0;
            accum_reg      <= 64'd0;
        end
        else
        begin
            hec_reg        <= hec_next;
            hoc_reg        <= hoc_next;
            hep_reg        <= hep_next;
            hop_reg        <= hop_next;
            odd_reg        <= odd_next;
            started_reg    <= started_next;
            space_reg      <= space_next;
            numeric_ok_reg <= numeric_ok_next;
            negative_reg   <= negative_next;
            digit_seen_reg <= digit_seen_next;
            saturated_reg  <= saturated_next;
            accum_reg      <= accum_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.last |=> !started_reg && numeric_ok_reg && accum_reg == 64'd0)
        else $error("state not cleared after end of string");

    a_sat_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
        saturated_reg |-> digit_seen_reg && started_reg)
        else $error("saturation without digits");

endmodule

// ----- rtl/tndh_mix.sv -----
// Finishing pipeline: split hash multiply, number sign/saturation, final
// add and output register. Depends on tndh_pkg and tndh_result_if.
module tndh_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fin_valid,
    input  tndh_pkg::fin_item_t fin,
    output logic                advance,
    tndh_result_if.source       result
);
    import tndh_pkg::*;

    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    fin_item_t   a_reg;
    res_kind_t   b_kind_reg;
    logic [63:0] b_h1_reg, b_num_reg;
    logic [62:0] b_plo_reg;
    logic [31:0] b_phi_reg;
    logic [63:0] value_reg;
    logic        was_numeric_reg;

    logic [62:0] plo_next;
    logic [31:0] phi_next;
    logic [63:0] num_next, value_next;

    assign advance            = !c_valid_reg || result.ready;
    assign result.valid       = c_valid_reg;
    assign result.value       = value_reg;
    assign result.was_numeric = was_numeric_reg;

    always_comb
    begin
        plo_next = 63'(a_reg.h_odd[31:0]) * 63'(MIX_MUL);
        phi_next = a_reg.h_odd[63:32] * 32'(MIX_MUL);
        unique case (a_reg.kind)
            RES_NUMBER:
            begin
                if (a_reg.negative)
                begin
                    num_next = a_reg.saturated ? MAG_LIMIT : (64'd0 - a_reg.accum);
                end
                else
                begin
                    num_next = (a_reg.saturated || a_reg.accum[63]) ? MAG_MAX : a_reg.accum;
                end
            end
            default:
            begin
                num_next = 64'd0;
            end
        endcase
        value_next = (b_kind_reg == RES_HASH)
                   ? b_h1_reg + {1'b0, b_plo_reg} + {b_phi_reg, 32'd0}
                   : b_num_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= fin_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg           <= fin;
            b_kind_reg      <= a_reg.kind;
            b_h1_reg        <= a_reg.h_even;
            b_plo_reg       <= plo_next;
            b_phi_reg       <= phi_next;
            b_num_reg       <= num_next;
            value_reg       <= value_next;
            was_numeric_reg <= (b_kind_reg == RES_NUMBER);
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(a_valid_reg) && $stable(b_valid_reg))
        else $error("pipeline moved during output stall");

endmodule

// ----- rtl/trimmed_numeric_or_dual_hash.sv -----
// Top level of the trimmed numeric-or-hash block.
// Depends on tndh_pkg, tndh_if, tndh_front, tndh_queue, tndh_back, tndh_mix.
//
// Usage:
//   text   : one byte item per handshake (byte_in, byte_valid, last). An item
//            with byte_valid low carries no byte; last closes the string.
//   result : one item per string, sent for the item that carries last:
//            value is the parsed signed decimal number (saturated to 64 bits)
//            when was_numeric is 1, otherwise the combined 64-bit hash of
//            the trimmed text, or 0 for an empty or all-blank string.
// Throughput: one byte item per cycle, sustained, including back-to-back
//   strings, as long as result is taken.
// Result path: the closing item's operands pass through the operand register,
//   the split multiply and the final add before result is valid.
// Stall: when result is not taken, the finishing pipeline and the byte
//   update hold; the two-entry queue absorbs up to two more items, then
//   text.ready drops.
// Reset: asynchronous, active low; the queue is emptied, the pipeline
//   holds no result and the string state returns to seed values.
module trimmed_numeric_or_dual_hash (
    input  logic          clk,
    input  logic          rst_n,
    tndh_text_if.sink     text,
    tndh_result_if.source result
);
    import tndh_pkg::*;

    cls_item_t front_item;
    cls_item_t queue_item;
    fin_item_t fin;
    logic      push, pop, q_empty, q_full, fin_valid, advance;

    assign pop = advance && !q_empty;

    tndh_front u_front (
        .text   (text),
        .q_full (q_full),
        .push   (push),
        .item   (front_item)
    );

    tndh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (front_item),
        .pop     (pop),
        .rd_item (queue_item),
        .empty   (q_empty),
        .full    (q_full)
    );

    tndh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .item      (queue_item),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    tndh_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .advance   (advance),
        .result    (result)
    );

endmodule

// ----- test/trimmed_numeric_or_dual_hash_tb.sv -----
// Testbench for trimmed_numeric_or_dual_hash: drives text strings byte by byte
// with random gaps and result stalls, and checks each result against a local
// numeric-parse / dual-hash predictor. Depends on tndh_pkg, tndh_if and the RTL.
module trimmed_numeric_or_dual_hash_tb;
    import tndh_pkg::*;

    localparam logic [63:0] HASH_SEED   = 64'd5381;
    localparam logic [63:0] HASH_MIX    = 64'd1566083941;
    localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TENTH_LIMIT = 64'd922337203685477580;
    localparam int          TARGET_BYTES = 1150;

    typedef bit [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] byte_in;
        logic       byte_valid;
        logic       last;
    } text_item_t;

    class parse_hash_board;
        typedef struct {
            logic [63:0] value;
            res_kind_t   kind;
        } outcome_t;

        outcome_t    expected_q[$];
        logic [63:0] even_done, odd_done, even_open, odd_open, accum;
        bit          odd_pos, started, blank_open, num_ok, negative, got_digit, saturated;
        int          errors, checked, n_numeric, n_hashed, n_empty;

        function new();
            clear_string();
        endfunction

        function void clear_string();
            even_done  = HASH_SEED;
            odd_done   = HASH_SEED;
            even_open  = HASH_SEED;
            odd_open   = HASH_SEED;
            accum      = '0;
            odd_pos    = 1'b0;
            started    = 1'b0;
            blank_open = 1'b0;
            num_ok     = 1'b1;
            negative   = 1'b0;
            got_digit  = 1'b0;
            saturated  = 1'b0;
        endfunction

        function void take_text(text_item_t it);
            logic [7:0]  b;
            logic [63:0] sx, t;
            bit          blank;
            outcome_t    want;
            b = it.byte_in;
            sx = {{56{b[7]}}, b};
            blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
            if (it.byte_valid && !(blank && !started))
            begin
                if (odd_pos)
                    odd_open = (odd_open * 64'd33) ^ sx;
                else
                    even_open = (even_open * 64'd33) ^ sx;
                odd_pos = !odd_pos;
                if (blank)
                begin
                    blank_open = 1'b1;
                end
                else
                begin
                    if (blank_open)
                        num_ok = 1'b0;
                    blank_open = 1'b0;
                    if (num_ok)
                    begin
                        if (!started && (b == "+" || b == "-"))
                        begin
                            negative = (b == "-");
                        end
                        else if (b >= "0" && b <= "9")
                        begin
                            got_digit = 1'b1;
                            if (!saturated)
                            begin
                                if (accum > TENTH_LIMIT)
                                begin
                                    saturated = 1'b1;
                                end
                                else
                                begin
                                    t = accum * 64'd10 + 64'(b - 8'h30);
                                    if (t > NEG_LIMIT)
                                        saturated = 1'b1;
                                    else
                                        accum = t;
                                end
                            end
                        end
                        else
                        begin
                            num_ok = 1'b0;
                        end
                    end
                    started   = 1'b1;
                    even_done = even_open;
                    odd_done  = odd_open;
                end
            end
            if (!it.last)
                return;
            if (!started)
            begin
                want.kind  = RES_EMPTY;
                want.value = '0;
                n_empty++;
            end
            else if (num_ok && got_digit)
            begin
                want.kind = RES_NUMBER;
                if (negative)
                    want.value = saturated ? NEG_LIMIT : (64'd0 - accum);
                else
                    want.value = (saturated || accum >= NEG_LIMIT) ? POS_LIMIT : accum;
                n_numeric++;
            end
            else
            begin
                want.kind  = RES_HASH;
                want.value = even_done + odd_done * HASH_MIX;
                n_hashed++;
            end
            expected_q.push_back(want);
            clear_string();
        endfunction

        function void check_value(logic [63:0] value, logic was_numeric);
            outcome_t want;
            bit       want_num;
            if (expected_q.size() == 0)
            begin
                $error("result with no string pending: value=%0d was_numeric=%0b",
                       $signed(value), was_numeric);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            want_num = (want.kind == RES_NUMBER);
            checked++;
            if (value !== want.value)
            begin
                $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
                errors++;
            end
            if (was_numeric !== want_num)
            begin
                $error("was_numeric: expected %0b, got %0b", want_num, was_numeric);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                $error("%0d results never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   bytes_sent;
    int   src_calm;
    int   sink_calm;
    int   sink_stall;

    parse_hash_board board = new();

    tndh_text_if   text_ch();
    tndh_result_if result_ch();

    trimmed_numeric_or_dual_hash u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    function automatic bit [7:0] digit_byte();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic bit [7:0] sign_byte();
        return $urandom_range(0, 1) ? "-" : "+";
    endfunction

    // 0x3A..0xFF: never a digit or a blank
    function automatic bit [7:0] junk_byte();
        return 8'(8'h3A + $urandom_range(0, 8'hC5));
    endfunction

    function automatic bit [7:0] any_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return blank_byte();
        if (r < 4)
            return digit_byte();
        if (r == 4)
            return sign_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 90)
            return $urandom_range(7, 18);
        return $urandom_range(19, 24);
    endfunction

    function automatic void append_str(ref byte_q_t s, input string x);
        for (int i = 0; i < x.len(); i++)
            s.push_back(x[i]);
    endfunction

    function automatic byte_q_t str_to_q(string x);
        byte_q_t s;
        append_str(s, x);
        return s;
    endfunction

    function automatic byte_q_t make_text();
        byte_q_t s;
        string   limit_digits[8] = '{"9223372036854775807", "9223372036854775808",
                                     "9223372036854775809", "922337203685477580",
                                     "9223372036854775810", "000009223372036854775808",
                                     "18446744073709551616", "99999999999999999999"};
        int      r;
        r = $urandom_range(0, 99);
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
            s.push_back(blank_byte());
        if (r < 40)
        begin
            if ($urandom_range(0, 2) == 0)
                s.push_back(sign_byte());
            repeat (digit_count())
                s.push_back(digit_byte());
        end
        else if (r < 50)
        begin
            if ($urandom_range(0, 2) != 0)
                s.push_back(sign_byte());
            append_str(s, limit_digits[$urandom_range(0, 7)]);
        end
        else if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    repeat (digit_count())
                        s.push_back(digit_byte());
                    repeat ($urandom_range(1, 2))
                        s.push_back(blank_byte());
                    repeat (digit_count())
                        s.push_back(digit_byte());
                end
                1:
                begin
                    if ($urandom_range(0, 1))
                        s.push_back(sign_byte());
                    repeat ($urandom_range(0, 4))
                        s.push_back(digit_byte());
                    s.push_back(junk_byte());
                    repeat ($urandom_range(0, 4))
                        s.push_back(digit_byte());
                end
                2:
                begin
                    s.push_back(sign_byte());
                end
                default:
                begin
                    repeat (digit_count())
                        s.push_back(digit_byte());
                    s.push_back(sign_byte());
                    repeat ($urandom_range(0, 3))
                        s.push_back(digit_byte());
                end
            endcase
        end
        else if (r < 88)
        begin
            repeat ($urandom_range(1, 12))
                s.push_back(any_byte());
        end
        else if (r >= 93)
        begin
            repeat ($urandom_range(13, 40))
                s.push_back(any_byte());
        end
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
            s.push_back(blank_byte());
        return s;
    endfunction

    task automatic send_item(input text_item_t it);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.byte_in    <= it.byte_in;
        text_ch.byte_valid <= it.byte_valid;
        text_ch.last       <= it.last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        board.take_text(it);
    endtask

    // empty items are sprinkled in; the string closes on its last byte or on an empty item
    task automatic send_text(input byte_q_t s);
        text_item_t items[$];
        text_item_t it;
        foreach (s[i])
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                it = '{byte_in: 8'($urandom_range(0, 255)), byte_valid: 1'b0, last: 1'b0};
                items.push_back(it);
            end
            it = '{byte_in: s[i], byte_valid: 1'b1, last: 1'b0};
            items.push_back(it);
        end
        if (s.size() == 0 || $urandom_range(0, 3) == 0)
        begin
            it = '{byte_in: 8'($urandom_range(0, 255)), byte_valid: 1'b0, last: 1'b1};
            items.push_back(it);
        end
        else
        begin
            items[items.size() - 1].last = 1'b1;
        end
        bytes_sent += items.size();
        foreach (items[i])
            send_item(items[i]);
    endtask

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            board.check_value(result_ch.value, result_ch.was_numeric);
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            sink_stall = pick_gap(sink_calm);
        end
    end

    initial
    begin
        string directed_texts[$];
        int    drain_cycles;
        directed_texts       = '{"", " \t\n\v\f\015 ", "0", " -42\n", "+7",
                                 "-9223372036854775808", "9223372036854775807",
                                 "-9223372036854775809", "+", "-", "1 2", "12a",
                                 "--5", "5-", "\v\f1\t", "ab cd  "};
        rst_n                = 1'b0;
        text_ch.valid        = 1'b0;
        text_ch.byte_in      = '0;
        text_ch.byte_valid   = 1'b0;
        text_ch.last         = 1'b0;
        bytes_sent           = 0;
        src_calm             = 0;
        sink_calm            = 0;
        sink_stall           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_texts[i])
            send_text(str_to_q(directed_texts[i]));
        send_text('{8'h00});
        send_text('{8'hFF, 8'h80, 8'h61});

        while (bytes_sent < TARGET_BYTES)
            send_text(make_text());
        text_ch.valid <= 1'b0;

        drain_cycles = 0;
        while (board.pending() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);
        board.close_out();

        $display("strings: %0d numeric, %0d hashed, %0d empty, over %0d input items",
                 board.n_numeric, board.n_hashed, board.n_empty, bytes_sent);
        $display("results checked: %0d, mismatches: %0d", board.checked, board.errors);
        if (board.errors == 0)
            $display("trimmed_numeric_or_dual_hash regression: pass");
        else
            $display("trimmed_numeric_or_dual_hash regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout waiting for the block");
        $display("trimmed_numeric_or_dual_hash regression: fail");
        $finish;
    end

endmodule
